// ----- rtl/core/trwa_pkg.sv -----
// Shared constants and codes for the timestamp ring window average unit.
`default_nettype none

package trwa_pkg;

  localparam int DepthDefault = 16;

  localparam int SecW   = 24;
  localparam int NsecW  = 30;
  localparam int EntW   = SecW + NsecW;
  localparam int SumW   = 60;
  localparam int MeanW  = 54;
  localparam int CountW = 7;

  localparam logic [NsecW-1:0] NsPerSec = NsecW'(1000000000);

  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/trwa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trwa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/timestamp_ring_window_average_unit.sv -----
// Top level: timestamp ring with running sum and bit-serial mean divider.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result is on the output ports for one
// cycle with done_o high and cannot be held off by the receiver. A push on a
// ring that is not full multiplies, adds and then runs the divider; a push on
// a full ring first does one RAM read, one extra multiply and subtract. A pop
// reads, multiplies, subtracts and divides; a pop that leaves the ring empty
// does no divide, and a pop on an empty ring goes straight to the result. The
// restoring divider makes one quotient bit per cycle over the 60-bit sum. The sec-to-ns multiply
// and the sum add/subtract share one unit, used once per sample touched.
`default_nettype none

module timestamp_ring_window_average_unit
  #(
  parameter int DEPTH = trwa_pkg::DepthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         op_i,
  input  wire logic [trwa_pkg::SecW-1:0]    sample_sec_i,
  input  wire logic [trwa_pkg::NsecW-1:0]   sample_nsec_i,
  output logic                              done_o,
  output logic      [trwa_pkg::SecW-1:0]    popped_sec_o,
  output logic      [trwa_pkg::NsecW-1:0]   popped_nsec_o,
  output logic                              popped_valid_o,
  output logic                              empty_error_o,
  output logic                              oldest_dropped_o,
  output logic      [trwa_pkg::CountW-1:0]  held_count_o,
  output logic      [trwa_pkg::MeanW-1:0]   mean_ns_o
);

  import trwa_pkg::*;

  localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int ItW   = $clog2(SumW);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StAcc  = 3'd3;
  localparam logic [2:0] StDld  = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] wr_idx_q, rd_idx_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] sum_q;
  logic            op_q, sub_q, err_q, drop_q, pvalid_q;
  logic [ItW-1:0]  it_q;

  logic [EntW-1:0] in_ent_q, ent_q;
  logic [EntW-1:0] prod_q;
  logic [SumW-1:0] quo_q;
  logic [CntW-1:0] rem_q;

  logic [EntW-1:0] ram_rdata;
  logic            ram_we, ram_re;
  logic            accept;
  logic            full;
  logic [SumW-1:0] ns_val;
  logic [CntW:0]   trial;
  logic [CntW:0]   trial_diff;
  logic            trial_ge;
  logic [CntW-1:0] rem_next;

  assign accept = start && !busy;
  assign full   = (cnt_q == CntW'(DEPTH));
  assign ram_re = accept;
  assign ram_we = (state_q == StAcc) && !sub_q;

  trwa_ram #(
    .Width (EntW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ent_q),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // shared arithmetic: entry in ns, then add or subtract into the sum
  assign ns_val = SumW'(prod_q) + SumW'(ent_q[NsecW-1:0]);

  // one restoring divide step
  assign trial      = {rem_q, quo_q[SumW-1]};
  assign trial_diff = trial - {1'b0, cnt_q};
  assign trial_ge   = (trial >= {1'b0, cnt_q});
  assign rem_next   = trial_ge ? trial_diff[CntW-1:0] : trial[CntW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (op_i == OpPop && cnt_q == '0) begin
            state_d = StDone;
          end else if (op_i == OpPop || full) begin
            state_d = StRd;
          end else begin
            state_d = StMul;
          end
        end
      end
      StRd:   state_d = StMul;
      StMul:  state_d = StAcc;
      StAcc: begin
        if (sub_q && op_q == OpPush) begin
          state_d = StMul;
        end else begin
          state_d = StDld;
        end
      end
      StDld: begin
        state_d = (cnt_q == '0) ? StDone : StDiv;
      end
      StDiv: begin
        if (it_q == ItW'(SumW - 1)) begin
          state_d = StDone;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
      op_q     <= OpPush;
      sub_q    <= 1'b0;
      err_q    <= 1'b0;
      drop_q   <= 1'b0;
      pvalid_q <= 1'b0;
      it_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (accept) begin
            op_q     <= op_i;
            err_q    <= (op_i == OpPop) && (cnt_q == '0);
            drop_q   <= (op_i == OpPush) && full;
            pvalid_q <= (op_i == OpPop) && (cnt_q != '0);
            sub_q    <= (op_i == OpPop) || full;
          end
        end
        StAcc: begin
          if (sub_q) begin
            sum_q    <= sum_q - ns_val;
            cnt_q    <= cnt_q - 1'b1;
            rd_idx_q <= (rd_idx_q == IdxW'(DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
            sub_q    <= 1'b0;
          end else begin
            sum_q    <= sum_q + ns_val;
            cnt_q    <= cnt_q + 1'b1;
            wr_idx_q <= (wr_idx_q == IdxW'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
          end
        end
        StDld:  it_q <= '0;
        StDiv:  it_q <= it_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          in_ent_q <= {sample_sec_i, sample_nsec_i};
          ent_q    <= {sample_sec_i, sample_nsec_i};
        end
      end
      StRd:  ent_q  <= ram_rdata;
      StMul: prod_q <= ent_q[EntW-1:NsecW] * NsPerSec;
      StAcc: begin
        if (sub_q && op_q == OpPush) begin
          ent_q <= in_ent_q;
        end
      end
      StDld: begin
        quo_q <= sum_q;
        rem_q <= '0;
      end
      StDiv: begin
        quo_q <= {quo_q[SumW-2:0], trial_ge};
        rem_q <= rem_next;
      end
      default: ;
    endcase
  end

  assign busy             = (state_q != StIdle);
  assign done_o           = (state_q == StDone);
  assign popped_valid_o   = pvalid_q;
  assign empty_error_o    = err_q;
  assign oldest_dropped_o = drop_q;
  assign popped_sec_o     = pvalid_q ? ent_q[EntW-1:NsecW] : '0;
  assign popped_nsec_o    = pvalid_q ? ent_q[NsecW-1:0] : '0;
  assign held_count_o     = CountW'(cnt_q);
  assign mean_ns_o        = (cnt_q == '0) ? '0 : quo_q[MeanW-1:0];

  a_done_ends_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy still high after result");

  a_accept_sets_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("fill count beyond ring depth");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({popped_valid_o, empty_error_o, oldest_dropped_o}))
    else $error("conflicting result flags");

endmodule

`default_nettype wire

// ----- dv/timestamp_ring_window_average_unit_test.sv -----
// Testbench for the timestamp ring window average unit: directed table plus random items.
`default_nettype none

module timestamp_ring_window_average_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import trwa_pkg::*;

  localparam int RingDepth = 16;
  localparam int RandomItems = 750;
  localparam int DirectedRows = 25;

  typedef struct packed {
    logic             op;
    logic [SecW-1:0]  sec;
    logic [NsecW-1:0] nsec;
  } sample_item_t;

  typedef struct packed {
    logic [SecW-1:0]   popped_sec;
    logic [NsecW-1:0]  popped_nsec;
    logic              popped_valid;
    logic              empty_error;
    logic              oldest_dropped;
    logic [CountW-1:0] held_count;
    logic [MeanW-1:0]  mean_ns;
  } ring_result_t;

  typedef struct {
    sample_item_t item;
    bit           typed;
    ring_result_t want;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic op_i = OpPush;
  logic [SecW-1:0] sample_sec_i = '0;
  logic [NsecW-1:0] sample_nsec_i = '0;
  logic done_o;
  logic [SecW-1:0] popped_sec_o;
  logic [NsecW-1:0] popped_nsec_o;
  logic popped_valid_o;
  logic empty_error_o;
  logic oldest_dropped_o;
  logic [CountW-1:0] held_count_o;
  logic [MeanW-1:0] mean_ns_o;

  timestamp_ring_window_average_unit #(
    .DEPTH(RingDepth)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .op_i(op_i),
    .sample_sec_i(sample_sec_i),
    .sample_nsec_i(sample_nsec_i),
    .done_o(done_o),
    .popped_sec_o(popped_sec_o),
    .popped_nsec_o(popped_nsec_o),
    .popped_valid_o(popped_valid_o),
    .empty_error_o(empty_error_o),
    .oldest_dropped_o(oldest_dropped_o),
    .held_count_o(held_count_o),
    .mean_ns_o(mean_ns_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow ring
  logic [EntW-1:0] ring_slots [RingDepth];
  int oldest_slot = 0;
  int next_slot = 0;
  int held_total = 0;
  logic [SumW-1:0] sum_ns = '0;

  ring_result_t pending_results [$];
  int errors = 0;

  function automatic logic [63:0] slot_ns(logic [EntW-1:0] entry);
    return 64'(entry[EntW-1:NsecW]) * 64'd1_000_000_000 + 64'(entry[NsecW-1:0]);
  endfunction

  function automatic logic [EntW-1:0] take_oldest_slot();
    logic [EntW-1:0] entry;
    entry = ring_slots[oldest_slot];
    oldest_slot = (oldest_slot + 1) % RingDepth;
    held_total--;
    sum_ns = sum_ns - SumW'(slot_ns(entry));
    return entry;
  endfunction

  function automatic ring_result_t ring_apply(sample_item_t it);
    ring_result_t r;
    logic [EntW-1:0] entry;
    r = '0;
    if (it.op == OpPush) begin
      if (held_total == RingDepth) begin
        entry = take_oldest_slot();
        r.oldest_dropped = 1'b1;
      end
      entry = {it.sec, it.nsec};
      ring_slots[next_slot] = entry;
      next_slot = (next_slot + 1) % RingDepth;
      held_total++;
      sum_ns = sum_ns + SumW'(slot_ns(entry));
    end else if (held_total == 0) begin
      r.empty_error = 1'b1;
    end else begin
      entry = take_oldest_slot();
      r.popped_sec = entry[EntW-1:NsecW];
      r.popped_nsec = entry[NsecW-1:0];
      r.popped_valid = 1'b1;
    end
    r.held_count = CountW'(held_total);
    r.mean_ns = (held_total != 0) ? MeanW'(64'(sum_ns) / 64'(held_total)) : '0;
    return r;
  endfunction

  function automatic void log_error(string what, ring_result_t want, ring_result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: exp sec=%h nsec=%h pv=%b err=%b drop=%b cnt=%0d mean=%0d",
               $realtime, what, want.popped_sec, want.popped_nsec, want.popped_valid,
               want.empty_error, want.oldest_dropped, want.held_count, want.mean_ns);
      $display("%0t %s: got sec=%h nsec=%h pv=%b err=%b drop=%b cnt=%0d mean=%0d",
               $realtime, what, got.popped_sec, got.popped_nsec, got.popped_valid,
               got.empty_error, got.oldest_dropped, got.held_count, got.mean_ns);
    end
  endfunction

  // drives one item and holds it until accepted; start stays high afterwards
  task automatic send_item(sample_item_t it, bit typed, ring_result_t want);
    ring_result_t predicted;
    start <= 1'b1;
    op_i <= it.op;
    sample_sec_i <= it.sec;
    sample_nsec_i <= it.nsec;
    do @(posedge clk_i); while (busy);
    predicted = ring_apply(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    ring_result_t got;
    ring_result_t want;
    if (rst_ni && done_o) begin
      got = '{popped_sec_o, popped_nsec_o, popped_valid_o, empty_error_o,
              oldest_dropped_o, held_count_o, mean_ns_o};
      if (pending_results.size() == 0) begin
        log_error("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          log_error("mismatch", want, got);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    directed_row_t rows [DirectedRows];
    ring_result_t none;
    sample_item_t it;
    int burst_left;
    int push_pct;
    int guard;

    none = '0;
    rows[0] = '{'{OpPop, 24'd0, 30'd0}, 1'b1,
                '{24'd0, 30'd0, 1'b0, 1'b1, 1'b0, 7'd0, 54'd0}};
    rows[1] = '{'{OpPush, 24'd0, 30'd0}, 1'b1,
                '{24'd0, 30'd0, 1'b0, 1'b0, 1'b0, 7'd1, 54'd0}};
    rows[2] = '{'{OpPop, 24'hFFFFFF, 30'h3FFFFFFF}, 1'b1,
                '{24'd0, 30'd0, 1'b1, 1'b0, 1'b0, 7'd0, 54'd0}};
    rows[3] = '{'{OpPop, 24'd0, 30'd0}, 1'b1,
                '{24'd0, 30'd0, 1'b0, 1'b1, 1'b0, 7'd0, 54'd0}};
    rows[4] = '{'{OpPush, 24'hFFFFFF, 30'd999999999}, 1'b1,
                '{24'd0, 30'd0, 1'b0, 1'b0, 1'b0, 7'd1, 54'd16777215999999999}};
    // nsec past one second is kept unnormalized
    rows[5] = '{'{OpPush, 24'd0, 30'h3FFFFFFF}, 1'b1,
                '{24'd0, 30'd0, 1'b0, 1'b0, 1'b0, 7'd2, 54'd8388608536870911}};
    rows[6] = '{'{OpPop, 24'd0, 30'd0}, 1'b1,
                '{24'hFFFFFF, 30'd999999999, 1'b1, 1'b0, 1'b0, 7'd1, 54'd1073741823}};
    rows[7] = '{'{OpPop, 24'd0, 30'd0}, 1'b1,
                '{24'd0, 30'h3FFFFFFF, 1'b1, 1'b0, 1'b0, 7'd0, 54'd0}};
    // fill the ring, last push drops the oldest
    for (int i = 8; i < DirectedRows; i++) begin
      rows[i] = '{'{OpPush, SecW'((i - 7) * 986131), NsecW'((i - 8) * 62500001)}, 1'b0, none};
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].typed, rows[i].want);
      if ($urandom_range(3) == 0) idle_cycles($urandom_range(1, 70));
    end
    drain_results();

    burst_left = 0;
    push_pct = 50;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 75;
          default: push_pct = 95;
        endcase
      end
      if (n == RandomItems / 2) drain_results();
      it.op = ($urandom_range(99) < push_pct) ? OpPush : OpPop;
      case ($urandom_range(7))
        0: it.sec = '0;
        1: it.sec = '1;
        default: it.sec = SecW'($urandom);
      endcase
      case ($urandom_range(7))
        0: it.nsec = '0;
        1: it.nsec = NsecW'(999999999);
        2: it.nsec = '1;
        3: it.nsec = NsecW'($urandom);
        default: it.nsec = NsecW'($urandom_range(999999999));
      endcase
      send_item(it, 1'b0, none);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 80));
      end else begin
        burst_left--;
      end
    end

    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- timestamp_ring_window_average_unit.f -----
rtl/core/trwa_pkg.sv
rtl/core/trwa_ram.sv
rtl/core/timestamp_ring_window_average_unit.sv
dv/timestamp_ring_window_average_unit_test.sv
